FILE: rtl/rgb_matrix_scan_refresh_macros.svh
// assertion macros used by the checker file
`ifndef RGB_MATRIX_SCAN_REFRESH_MACROS_SVH
`define RGB_MATRIX_SCAN_REFRESH_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RMSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RMSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rmsr_pkg.sv
package rmsr_pkg;

    // panel geometry and color depth
    localparam int PANEL_COLUMNS = 64;
    localparam int SCAN_ROWS     = 16;
    localparam int CHANNEL_BITS  = 5;

    localparam int PANEL_ROWS  = 2 * SCAN_ROWS;
    localparam int COL_W       = $clog2(PANEL_COLUMNS);
    localparam int ROW_W       = $clog2(SCAN_ROWS);
    localparam int HALF_DEPTH  = PANEL_COLUMNS * SCAN_ROWS;
    localparam int ADDR_W      = $clog2(HALF_DEPTH);
    localparam int COLOR_W     = 3 * CHANNEL_BITS;
    localparam int PWM_LAST    = (1 << CHANNEL_BITS) - 2;

    // fixed field widths of the transactions
    localparam int FIELD_W    = 16;
    localparam int RGB_W      = 3;
    localparam int ROW_ADDR_W = 4;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef logic [COLOR_W-1:0]      t_color;
    typedef logic [CHANNEL_BITS-1:0] t_level;

    typedef struct packed {
        logic                      operation;
        logic signed [FIELD_W-1:0] pixel_x;
        logic signed [FIELD_W-1:0] pixel_y;
        logic [FIELD_W-1:0]        pixel_color;
    } t_in_item;

    typedef struct packed {
        logic [RGB_W-1:0]      upper_rgb;
        logic [RGB_W-1:0]      lower_rgb;
        logic [ROW_ADDR_W-1:0] row_address;
        logic                  latch_last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_we;
        logic pix_we;
        logic tick;
        logic issue;
        logic load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic col_last;
    } t_dp_sts;

    // keep the color bits that the store holds
    function automatic t_color to_color(input logic [FIELD_W-1:0] v);
        return COLOR_W'({{COLOR_W{1'b0}}, v});
    endfunction

    // mirror a pwm frame count into its threshold
    function automatic t_level bit_reverse(input t_level v);
        t_level r;
        r = '0;
        for (int i = 0; i < CHANNEL_BITS; i++) begin
            r[CHANNEL_BITS-1-i] = v[i];
        end
        return r;
    endfunction

    // one flag per channel: channel level above threshold
    function automatic logic [RGB_W-1:0] channel_flags(input t_color c, input t_level thr);
        logic [RGB_W-1:0] f;
        for (int ch = 0; ch < RGB_W; ch++) begin
            f[ch] = c[ch*CHANNEL_BITS +: CHANNEL_BITS] > thr;
        end
        return f;
    endfunction

    // low bits of the scan row for the address pins
    function automatic logic [ROW_ADDR_W-1:0] row_field(input logic [ROW_W-1:0] r);
        return ROW_ADDR_W'({{ROW_ADDR_W{1'b0}}, r});
    endfunction

endpackage

FILE: rtl/rgb_matrix_scan_refresh.sv
// Refresh engine for a two-half scanned RGB matrix panel.
// Input channel (i_in_valid / o_in_stall / i_in_data): a transaction is either a
// pixel write, which stores a color in the frame store (writes off the panel are
// dropped), or a refresh tick, which advances the scan row and, on row wrap, the
// pwm frame, then shifts out one result per column.
// Output channel (o_out_valid / i_out_stall / o_out_data): per column the upper
// and lower half channel bits, the row address, and latch_last on the last column.
// Pixel write: taken with no result. Refresh tick: one read per cycle from each
// half store and one result per cycle while the output is not stalled, 64 in all,
// through a registered read and an output register; the next tick waits until the
// scan has drained into the output register.
// Reset: the row and pwm counters return to their start values and a clearing
// pass writes zero to both half stores with o_in_stall high.
// A stalled receiver holds the output register; reads stop until it is taken,
// and the input stays stalled until the scan has drained into the register.
module rgb_matrix_scan_refresh (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rmsr_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rmsr_pkg::t_out_item o_out_data
);

    rmsr_pkg::t_dp_cmd cmd;
    rmsr_pkg::t_dp_sts sts;

    // sequencing and flow control
    rmsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_data.operation),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // frame store, counters and compare
    rmsr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

FILE: rtl/rmsr_ctrl.sv
module rmsr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_op,
    input  logic             i_out_stall,
    input  rmsr_pkg::t_dp_sts i_sts,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output rmsr_pkg::t_dp_cmd o_cmd
);

    rmsr_pkg::t_state r_state, n_state;
    logic             r_pend, n_pend;
    logic             r_out_vld, n_out_vld;
    logic             accept;
    logic             load;
    logic             issue;

    // handshake and pipeline flow
    always_comb begin
        accept = (r_state == rmsr_pkg::ST_IDLE) && i_in_valid;
        load   = r_pend && (!r_out_vld || !i_out_stall);
        issue  = (r_state == rmsr_pkg::ST_SCAN) && (!r_pend || load);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rmsr_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = rmsr_pkg::ST_IDLE;
                end
            end
            rmsr_pkg::ST_IDLE: begin
                if (accept && (i_in_op == rmsr_pkg::OP_TICK)) begin
                    n_state = rmsr_pkg::ST_SCAN;
                end
            end
            rmsr_pkg::ST_SCAN: begin
                if (issue && i_sts.col_last) begin
                    n_state = rmsr_pkg::ST_DRAIN;
                end
            end
            rmsr_pkg::ST_DRAIN: begin
                if (!r_pend) begin
                    n_state = rmsr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rmsr_pkg::ST_CLEAR;
            end
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        o_cmd.load   = load;
        o_cmd.issue  = issue;
        case (r_state)
            rmsr_pkg::ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
            end
            rmsr_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.pix_we = accept && (i_in_op == rmsr_pkg::OP_WRITE);
                o_cmd.tick   = accept && (i_in_op == rmsr_pkg::OP_TICK);
            end
            rmsr_pkg::ST_SCAN, rmsr_pkg::ST_DRAIN: begin
                o_in_stall = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // read data and output register occupancy
    always_comb begin
        n_pend    = issue || (r_pend && !load);
        n_out_vld = load || (r_out_vld && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rmsr_pkg::ST_CLEAR;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

FILE: rtl/rmsr_dp.sv
module rmsr_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rmsr_pkg::t_dp_cmd  i_cmd,
    input  rmsr_pkg::t_in_item i_in_data,
    output rmsr_pkg::t_dp_sts  o_sts,
    output rmsr_pkg::t_out_item o_out_data
);

    rmsr_pkg::t_color r_mem_upper [rmsr_pkg::HALF_DEPTH];
    rmsr_pkg::t_color r_mem_lower [rmsr_pkg::HALF_DEPTH];

    logic [rmsr_pkg::ADDR_W-1:0] r_clr, n_clr;
    logic [rmsr_pkg::ROW_W-1:0]  r_row, n_row;
    rmsr_pkg::t_level            r_pwm, n_pwm;
    logic [rmsr_pkg::COL_W-1:0]  r_col, n_col;

    rmsr_pkg::t_color    r_rd_upper;
    rmsr_pkg::t_color    r_rd_lower;
    logic                r_rd_last;
    rmsr_pkg::t_out_item r_out;

    logic [rmsr_pkg::FIELD_W-1:0] px;
    logic [rmsr_pkg::FIELD_W-1:0] py;
    logic [rmsr_pkg::FIELD_W-1:0] py_low;
    logic                         x_ok;
    logic                         y_upper;
    logic                         y_lower;
    logic [rmsr_pkg::ROW_W-1:0]   pix_row;
    logic [rmsr_pkg::ADDR_W-1:0]  pix_addr;
    logic [rmsr_pkg::ADDR_W-1:0]  waddr;
    rmsr_pkg::t_color             wdata;
    logic                         we_upper;
    logic                         we_lower;
    logic [rmsr_pkg::ADDR_W-1:0]  raddr;
    rmsr_pkg::t_level             thr;
    logic                         clr_last;
    logic                         col_last;

    // pixel write decode: negative coordinates read as large unsigned values
    always_comb begin
        px       = $unsigned(i_in_data.pixel_x);
        py       = $unsigned(i_in_data.pixel_y);
        py_low   = py - rmsr_pkg::FIELD_W'(rmsr_pkg::SCAN_ROWS);
        x_ok     = px < rmsr_pkg::FIELD_W'(rmsr_pkg::PANEL_COLUMNS);
        y_upper  = py < rmsr_pkg::FIELD_W'(rmsr_pkg::SCAN_ROWS);
        y_lower  = !y_upper && (py < rmsr_pkg::FIELD_W'(rmsr_pkg::PANEL_ROWS));
        pix_row  = y_upper ? py[rmsr_pkg::ROW_W-1:0] : py_low[rmsr_pkg::ROW_W-1:0];
        pix_addr = rmsr_pkg::ADDR_W'(pix_row) * rmsr_pkg::ADDR_W'(rmsr_pkg::PANEL_COLUMNS)
                 + rmsr_pkg::ADDR_W'(px[rmsr_pkg::COL_W-1:0]);
    end

    // write port: clearing sweep or pixel write
    always_comb begin
        if (i_cmd.clr_we) begin
            waddr    = r_clr;
            wdata    = '0;
            we_upper = 1'b1;
            we_lower = 1'b1;
        end else begin
            waddr    = pix_addr;
            wdata    = rmsr_pkg::to_color(i_in_data.pixel_color);
            we_upper = i_cmd.pix_we && x_ok && y_upper;
            we_lower = i_cmd.pix_we && x_ok && y_lower;
        end
    end

    // read address of the current column in both halves
    always_comb begin
        raddr = rmsr_pkg::ADDR_W'(r_row) * rmsr_pkg::ADDR_W'(rmsr_pkg::PANEL_COLUMNS)
              + rmsr_pkg::ADDR_W'(r_col);
    end

    // upper half store
    always_ff @(posedge i_clk) begin
        if (we_upper) begin
            r_mem_upper[waddr] <= wdata;
        end
        if (i_cmd.issue) begin
            r_rd_upper <= r_mem_upper[raddr];
        end
    end

    // lower half store
    always_ff @(posedge i_clk) begin
        if (we_lower) begin
            r_mem_lower[waddr] <= wdata;
        end
        if (i_cmd.issue) begin
            r_rd_lower <= r_mem_lower[raddr];
        end
    end

    // counters: clear sweep, scan row, pwm frame, column
    always_comb begin
        clr_last = r_clr == rmsr_pkg::ADDR_W'(rmsr_pkg::HALF_DEPTH - 1);
        col_last = r_col == rmsr_pkg::COL_W'(rmsr_pkg::PANEL_COLUMNS - 1);

        n_clr = r_clr;
        if (i_cmd.clr_we) begin
            n_clr = r_clr + 1'b1;
        end

        n_row = r_row;
        n_pwm = r_pwm;
        if (i_cmd.tick) begin
            if (r_row == rmsr_pkg::ROW_W'(rmsr_pkg::SCAN_ROWS - 1)) begin
                n_row = '0;
                if (r_pwm == rmsr_pkg::CHANNEL_BITS'(rmsr_pkg::PWM_LAST)) begin
                    n_pwm = '0;
                end else begin
                    n_pwm = r_pwm + 1'b1;
                end
            end else begin
                n_row = r_row + 1'b1;
            end
        end

        n_col = r_col;
        if (i_cmd.tick) begin
            n_col = '0;
        end else if (i_cmd.issue) begin
            n_col = col_last ? '0 : r_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_row <= rmsr_pkg::ROW_W'(rmsr_pkg::SCAN_ROWS - 1);
            r_pwm <= rmsr_pkg::CHANNEL_BITS'(rmsr_pkg::PWM_LAST);
            r_col <= '0;
        end else begin
            r_clr <= n_clr;
            r_row <= n_row;
            r_pwm <= n_pwm;
            r_col <= n_col;
        end
    end

    // last column flag follows its read
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_last <= col_last;
        end
    end

    // threshold compare into the output register
    assign thr = rmsr_pkg::bit_reverse(r_pwm);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.upper_rgb   <= rmsr_pkg::channel_flags(r_rd_upper, thr);
            r_out.lower_rgb   <= rmsr_pkg::channel_flags(r_rd_lower, thr);
            r_out.row_address <= rmsr_pkg::row_field(r_row);
            r_out.latch_last  <= r_rd_last;
        end
    end

    assign o_sts.clr_last = clr_last;
    assign o_sts.col_last = col_last;
    assign o_out_data     = r_out;

endmodule

FILE: rtl/rmsr_checker.sv
`include "rgb_matrix_scan_refresh_macros.svh"

module rmsr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input rmsr_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rmsr_pkg::t_out_item o_out_data
);

    logic in_take;

    assign in_take  = i_in_valid && !o_in_stall;

    // a stalled result transaction holds
    `RMSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    // a result before the last column means a scan is running
    `RMSR_ASSERT_SAME(a_busy_mid_scan, i_clk, i_rst_n, o_out_valid && !o_out_data.latch_last, o_in_stall, "input ready during a scan")

    // an accepted tick blocks the input while it scans
    `RMSR_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, in_take && (i_in_data.operation == rmsr_pkg::OP_TICK), o_in_stall, "input ready right after a tick")

    // a pixel write never raises a result
    `RMSR_ASSERT_NEXT(a_write_quiet, i_clk, i_rst_n, in_take && (i_in_data.operation == rmsr_pkg::OP_WRITE) && !o_out_valid, !o_out_valid, "result after a pixel write")

endmodule

bind rgb_matrix_scan_refresh rmsr_checker u_rmsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
